/* hw/rtl/mdds_pkg.sv */
// ----------------------------------------------------------------------------
// mdds_pkg
// Types, codes and constants shared by the decimal display scan block.
// ----------------------------------------------------------------------------
package mdds_pkg;

	localparam int unsigned NUM_WIDTH   = 16;
	localparam int unsigned DIGIT_WIDTH = 4;
	localparam int unsigned PLACE_WIDTH = 2;
	localparam int unsigned NUM_DIGITS  = 4;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	localparam logic [DIGIT_WIDTH-1:0] BLANK_DIGIT     = 4'd10;
	localparam logic [PLACE_WIDTH-1:0] TOP_PLACE_RESET = 2'd3;

	typedef logic [NUM_DIGITS-1:0][DIGIT_WIDTH-1:0] digits_t;

	typedef struct packed {
		logic    rejected;
		digits_t digits;
	} split_t;

	typedef struct packed {
		logic load;
		logic tick;
	} scan_ctrl_t;

	// Limit for a number that fits in places 0..top: ten to the power top + 1.
	function automatic logic [NUM_WIDTH-2:0] place_limit(input logic [PLACE_WIDTH-1:0] top);
		logic [NUM_WIDTH-2:0] lim;
		case (top)
			2'd0:    lim = 15'd10;
			2'd1:    lim = 15'd100;
			2'd2:    lim = 15'd1000;
			2'd3:    lim = 15'd10000;
			default: lim = 15'd10000;
		endcase
		return lim;
	endfunction

endpackage

/* hw/rtl/mdds_in_if.sv */
// ----------------------------------------------------------------------------
// mdds_in_if
// Input channel: load or refresh tick with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mdds_in_if;
	logic               valid;
	logic               ready;
	logic               func;
	logic signed [15:0] number;

	modport source (output valid, output func, output number, input ready);
	modport sink   (input valid, input func, input number, output ready);
endinterface

/* hw/rtl/mdds_out_if.sv */
// ----------------------------------------------------------------------------
// mdds_out_if
// Result channel: digit place and value, or load status.
// ----------------------------------------------------------------------------
interface mdds_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] digit_select;
	logic [3:0] digit_value;
	logic       display_valid;
	logic       number_rejected;

	modport source (output valid, output digit_select, output digit_value,
		output display_valid, output number_rejected, input ready);
	modport sink   (input valid, input digit_select, input digit_value,
		input display_valid, input number_rejected, output ready);
endinterface

/* hw/rtl/mdds_split.sv */
// ----------------------------------------------------------------------------
// mdds_split
// Range check and binary to decimal split of a load number. Each quotient
// comes from one reciprocal multiply of the input, exact below 10000.
// ----------------------------------------------------------------------------
module mdds_split (
	input  logic signed [15:0] number,
	input  logic [1:0]         top,
	output mdds_pkg::split_t   split
);
	import mdds_pkg::*;

	logic [14:0] v;
	logic [30:0] p1;
	logic [27:0] p2;
	logic [29:0] p3;
	logic [11:0] q1;
	logic [8:0]  q2;
	logic [5:0]  q3;
	logic [14:0] r0;
	logic [11:0] r1;
	logic [8:0]  r2;

	assign v  = number[14:0];
	assign p1 = 31'(v) * 31'd52429;
	assign p2 = 28'(v) * 28'd5243;
	assign p3 = 30'(v) * 30'd16778;
	assign q1 = p1[30:19];
	assign q2 = p2[27:19];
	assign q3 = p3[29:24];

	assign r0 = v - 15'({q1, 3'b000}) - 15'({q1, 1'b0});
	assign r1 = q1 - 12'({q2, 3'b000}) - 12'({q2, 1'b0});
	assign r2 = q2 - 9'({q3, 3'b000}) - 9'({q3, 1'b0});

	assign split.rejected  = number[15] || (v >= place_limit(top));
	assign split.digits[0] = r0[3:0];
	assign split.digits[1] = r1[3:0];
	assign split.digits[2] = r2[3:0];
	assign split.digits[3] = q3[3:0];

endmodule

/* hw/rtl/mdds_scan.sv */
// ----------------------------------------------------------------------------
// mdds_scan
// Digit store and scan place counter; picks the place for a tick.
// ----------------------------------------------------------------------------
module mdds_scan #(
	parameter int MAX_PLACES = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mdds_pkg::scan_ctrl_t ctrl,
	input  mdds_pkg::digits_t    digits,
	input  logic [1:0]           top,
	output logic [1:0]           place,
	output logic [3:0]           value
);
	import mdds_pkg::*;

	localparam int IDX_W = (MAX_PLACES > 1) ? $clog2(MAX_PLACES) : 1;

	logic [DIGIT_WIDTH-1:0] store_q [MAX_PLACES];
	logic [PLACE_WIDTH-1:0] scan_q;
	logic [IDX_W-1:0]       idx;

	assign place = (scan_q > top) ? '0 : scan_q;
	assign idx   = place[IDX_W-1:0];
	assign value = store_q[idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
		end else if (ctrl.tick) begin
			scan_q <= place + 2'd1;
		end
	end

	for (genvar p = 0; p < MAX_PLACES; p++) begin : g_store
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				store_q[p] <= BLANK_DIGIT;
			end else if (ctrl.load) begin
				store_q[p] <= digits[p];
			end
		end
	end

endmodule

/* hw/rtl/multiplexed_decimal_display_scan.sv */
// ----------------------------------------------------------------------------
// multiplexed_decimal_display_scan
// Scan controller for a multiplexed decimal display of up to four places.
//
// req carries func and number. A load (func 0) splits a non-negative number
// below ten to the power of the places in use into decimal digits; other
// numbers are rejected and the stored digits hold. A tick (func 1) drives
// the next place, wrapping after top_place, and returns place and digit.
// rsp returns exactly one result per item.
// cfg_wr_en / cfg_wr_data write top_place; write only while the block idles.
// A transfer on req is held in the input register, then the split or store
// read goes into the result register, which drives rsp.
// Throughput is one item per cycle while rsp does not stall. While a result
// waits on a stalled rsp, req still takes one item into an empty input
// register, then holds ready low until rsp takes the waiting result.
// Reset clears both stages, shows all places blank, sets the scan to the
// units place and top_place to 3.
// ----------------------------------------------------------------------------
module multiplexed_decimal_display_scan #(
	parameter int MAX_PLACES = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	mdds_in_if.sink    req,
	mdds_out_if.source rsp,
	input  logic       cfg_wr_en,
	input  logic [1:0] cfg_wr_data
);
	import mdds_pkg::*;

	localparam logic [PLACE_WIDTH-1:0] TOP_LIMIT = PLACE_WIDTH'(MAX_PLACES - 1);

	logic                   valid_s1;
	logic                   func_s1;
	logic signed [15:0]     number_s1;
	logic [PLACE_WIDTH-1:0] top_place_q;
	logic [PLACE_WIDTH-1:0] top;
	logic                   rsp_valid_q;
	logic [1:0]             select_q;
	logic [3:0]             value_q;
	logic                   disp_q;
	logic                   rej_q;
	logic                   advance;
	split_t                 split;
	scan_ctrl_t             ctrl;
	logic [1:0]             place;
	logic [3:0]             value;

	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign top       = (top_place_q > TOP_LIMIT) ? TOP_LIMIT : top_place_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_place_q <= TOP_PLACE_RESET;
		end else if (cfg_wr_en) begin
			top_place_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			func_s1   <= req.func;
			number_s1 <= req.number;
		end
	end

	mdds_split u_split (
		.number (number_s1),
		.top    (top),
		.split  (split)
	);

	assign ctrl.load = advance && (func_s1 == FUNC_LOAD) && !split.rejected;
	assign ctrl.tick = advance && (func_s1 == FUNC_TICK);

	mdds_scan #(
		.MAX_PLACES (MAX_PLACES)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.digits (split.digits),
		.top    (top),
		.place  (place),
		.value  (value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (func_s1 == FUNC_TICK) begin
				select_q <= place;
				value_q  <= value;
				disp_q   <= 1'b1;
				rej_q    <= 1'b0;
			end else begin
				select_q <= '0;
				value_q  <= '0;
				disp_q   <= 1'b0;
				rej_q    <= split.rejected;
			end
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.digit_select    = select_q;
	assign rsp.digit_value     = value_q;
	assign rsp.display_valid   = disp_q;
	assign rsp.number_rejected = rej_q;

endmodule

/* hw/rtl/mdds_checker.sv */
// ----------------------------------------------------------------------------
// mdds_checker
// Port-level checks on the result channel of the display scan block.
// ----------------------------------------------------------------------------
module mdds_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [1:0] digit_select,
	input logic [3:0] digit_value,
	input logic       display_valid,
	input logic       number_rejected
);
	import mdds_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(digit_select)
			&& $stable(digit_value) && $stable(display_valid)
			&& $stable(number_rejected))
		else $error("result changed while stalled");

	a_kind_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(display_valid && number_rejected))
		else $error("tick result flagged as rejected");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && display_valid |-> digit_value <= BLANK_DIGIT)
		else $error("digit value out of range");

	a_load_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !display_valid |-> digit_select == 2'd0 && digit_value == 4'd0)
		else $error("load result carries a digit");

endmodule

bind multiplexed_decimal_display_scan mdds_checker u_mdds_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.digit_select    (rsp.digit_select),
	.digit_value     (rsp.digit_value),
	.display_valid   (rsp.display_valid),
	.number_rejected (rsp.number_rejected)
);
